[hw/rtl/wrq_pkg.sv]
// ----------------------------------------------------------------------------
// wrq_pkg
// Types and codes shared by the worker ready queue.
// ----------------------------------------------------------------------------
package wrq_pkg;

	localparam int REQ_BITS = 3;
	localparam int STATUS_BITS = 3;
	localparam int CNT_OUT_BITS = 5;
	localparam int FIELD_ID_BITS = 32;
	localparam int LIFE_BITS = 16;
	localparam logic [LIFE_BITS-1:0] LIFE_RESET = 16'd3000;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_READY     = 3'd0,
		REQ_HEARTBEAT = 3'd1,
		REQ_RELEASE   = 3'd2,
		REQ_DEQUEUE   = 3'd3,
		REQ_TICK      = 3'd4
	} req_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK     = 3'd0,
		ST_DUP    = 3'd1,
		ST_ABSENT = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef struct packed {
		logic [REQ_BITS-1:0]      req_type;
		logic [FIELD_ID_BITS-1:0] worker_id;
	} wrq_in_t;

	typedef struct packed {
		logic [FIELD_ID_BITS-1:0] served_id;
		logic [STATUS_BITS-1:0]   status;
		logic [CNT_OUT_BITS-1:0]  occupancy;
		logic [CNT_OUT_BITS-1:0]  purged_count;
	} wrq_out_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_MOVE,
		FSM_DONE
	} fsm_t;

endpackage

[hw/rtl/worker_ready_queue_with_expiry.sv]
// ----------------------------------------------------------------------------
// worker_ready_queue_with_expiry
// Ordered queue of idle workers with expiry, held in one synchronous memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// request   in         start, busy, req
// result    out        done, rsp
// config    in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// An item passes from acceptance to the result strobe through one pass over the
// live entries, one entry per cycle through the single read port, that searches
// and compacts together, then the DECIDE and DONE states. busy is high from
// acceptance until the cycle of the result strobe, in which the next item can
// already be accepted.
// Reset clears the count and the tick clock and sets the lifetime to 3000.
// The result is shown for one cycle and cannot be stalled.
module worker_ready_queue_with_expiry import wrq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS = 32,
	parameter int TIME_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  wrq_in_t       req,
	output logic          done,
	output wrq_out_t      rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = ID_BITS + TIME_BITS;

	logic [EW-1:0] mem [QUEUE_DEPTH];
	logic [EW-1:0] rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;

	fsm_t state_q, state_d;
	logic [CW-1:0] count_q, rd_q, wr_q, removed_q, pos_q;
	logic [CW-1:0] count_d, rd_d, wr_d, removed_d, pos_d;
	logic          found_q, found_d;
	logic          rd_valid_q;
	logic [TIME_BITS-1:0] now_q, now_d;
	logic [LIFE_BITS-1:0] life_q;
	logic [REQ_BITS-1:0]  op_q;
	logic [ID_BITS-1:0]   id_q;
	logic [ID_BITS-1:0]   served_q, served_d;
	logic [STATUS_BITS-1:0] status_q, status_d;
	logic [CW-1:0] occ_q, occ_d, purged_q, purged_d;

	logic [ID_BITS-1:0]   rd_id;
	logic [TIME_BITS-1:0] rd_exp, diff, fresh_exp;
	logic                 rd_expired, match;
	logic                 accept;

	assign accept = start && !busy;
	assign rd_id = rd_data_q[EW-1:TIME_BITS];
	assign rd_exp = rd_data_q[TIME_BITS-1:0];
	assign diff = now_q - rd_exp;
	assign rd_expired = (diff != '0) && !diff[TIME_BITS-1];
	assign match = (rd_id == id_q);
	assign fresh_exp = now_q + TIME_BITS'(life_q);

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? 32'(life_q) : 32'd0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= LIFE_RESET;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			life_q <= pwdata[LIFE_BITS-1:0];
		end
	end

	// The scan walks rd over the live entries; wr is the compaction write
	// pointer. A read issued in one cycle is examined in the next.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		rd_d = rd_q;
		wr_d = wr_q;
		removed_d = removed_q;
		pos_d = pos_q;
		found_d = found_q;
		now_d = now_q;
		served_d = served_q;
		status_d = status_q;
		occ_d = occ_q;
		purged_d = purged_q;
		mem_we = 1'b0;
		mem_waddr = wr_q[AW-1:0];
		mem_wdata = rd_data_q;
		mem_raddr = rd_q[AW-1:0];
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					rd_d = '0;
					wr_d = '0;
					removed_d = '0;
					found_d = 1'b0;
					pos_d = '0;
					served_d = '0;
					status_d = ST_OK;
					purged_d = '0;
					mem_raddr = '0;
					if (req.req_type == REQ_TICK) begin
						now_d = now_q + 1'b1;
					end
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				// Issue reads 0..count-1; rd_valid_q marks data present.
				if (rd_valid_q) begin
					priority if (op_q == REQ_TICK) begin
						if (rd_expired) begin
							removed_d = removed_q + 1'b1;
						end else begin
							mem_we = 1'b1;
							wr_d = wr_q + 1'b1;
						end
					end else if (op_q == REQ_DEQUEUE) begin
						if (wr_q == '0) begin
							served_d = rd_id;
						end else begin
							mem_we = 1'b1;
							mem_waddr = AW'(wr_q - 1'b1);
						end
						wr_d = wr_q + 1'b1;
					end else if (op_q == REQ_READY) begin
						if (found_q) begin
							mem_we = 1'b1;
							mem_waddr = AW'(wr_q - 1'b1);
						end else if (match) begin
							found_d = 1'b1;
						end
						wr_d = wr_q + 1'b1;
					end else begin
						if (!found_q && match) begin
							found_d = 1'b1;
							pos_d = wr_q;
						end
						wr_d = wr_q + 1'b1;
					end
				end
				if (rd_q < count_q) begin
					rd_d = rd_q + 1'b1;
				end else if (!rd_valid_q || rd_q == count_q) begin
					state_d = FSM_DECIDE;
				end
			end
			FSM_DECIDE: begin
				mem_wdata = {id_q, fresh_exp};
				unique case (op_q)
					REQ_READY: begin
						if (found_q) begin
							mem_we = 1'b1;
							mem_waddr = AW'(count_q - 1'b1);
						end else if (count_q >= CW'(QUEUE_DEPTH)) begin
							status_d = ST_FULL;
						end else begin
							mem_we = 1'b1;
							mem_waddr = count_q[AW-1:0];
							count_d = count_q + 1'b1;
						end
					end
					REQ_HEARTBEAT: begin
						if (found_q) begin
							mem_we = 1'b1;
							mem_waddr = pos_q[AW-1:0];
						end else begin
							status_d = ST_ABSENT;
						end
					end
					REQ_RELEASE: begin
						if (found_q) begin
							status_d = ST_DUP;
						end else if (count_q >= CW'(QUEUE_DEPTH)) begin
							status_d = ST_FULL;
						end else begin
							mem_we = 1'b1;
							mem_waddr = count_q[AW-1:0];
							count_d = count_q + 1'b1;
						end
					end
					REQ_DEQUEUE: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
						end else begin
							count_d = count_q - 1'b1;
						end
					end
					REQ_TICK: begin
						count_d = wr_q;
						purged_d = removed_q;
					end
					default: begin
					end
				endcase
				state_d = FSM_DONE;
			end
			FSM_DONE: begin
				occ_d = count_q;
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			now_q <= '0;
			rd_valid_q <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			now_q <= now_d;
			rd_valid_q <= (state_d == FSM_SCAN) && (rd_d != '0) && (rd_d <= count_q)
				&& (state_q == FSM_IDLE || rd_d != rd_q);
			done <= (state_q == FSM_DONE);
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= rd_d;
		wr_q <= wr_d;
		removed_q <= removed_d;
		pos_q <= pos_d;
		found_q <= found_d;
		served_q <= served_d;
		status_q <= status_d;
		occ_q <= occ_d;
		purged_q <= purged_d;
		if (accept) begin
			op_q <= req.req_type;
			id_q <= ID_BITS'(req.worker_id);
		end
	end

	assign busy = (state_q != FSM_IDLE);

	always_comb begin
		rsp = '0;
		rsp.served_id = FIELD_ID_BITS'(served_q);
		rsp.status = status_q;
		rsp.occupancy = CNT_OUT_BITS'(occ_q);
		rsp.purged_count = CNT_OUT_BITS'(purged_q);
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work");
	a_now_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_IDLE) |=> $stable(now_q))
		else $error("clock moved during work");
`endif

endmodule
